FILE: sv/sacc_pkg.sv
// Shared types and constants for the saturating accumulator ALU.
package sacc_pkg;

    localparam int ACC_W  = 21;
    localparam int MAG_W  = 20;
    localparam int OPD_W  = 9;
    localparam int SUM_W  = 22;
    localparam int PROD_W = 29;

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [MAG_W-1:0]        mag_t;
    typedef logic [OPD_W-1:0]        opd_t;
    typedef logic [SUM_W-1:0]        sum_t;
    typedef logic [PROD_W-1:0]       prod_t;

    localparam logic [3:0] CMD_ADD  = 4'd1;
    localparam logic [3:0] CMD_SUB  = 4'd2;
    localparam logic [3:0] CMD_MUL  = 4'd4;
    localparam logic [3:0] CMD_DIV  = 4'd8;
    localparam logic [3:0] CMD_STOP = 4'd9;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic [3:0] cmd;
        logic [9:0] switches;
    } in_t;

    typedef struct packed {
        acc_t accumulator;
        logic negative;
        logic stopped;
    } out_t;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
        acc_t       acc;
        opd_t       opd_mag;
        logic       opd_neg;
    } req_t;

    typedef struct packed {
        logic done;
        acc_t result;
    } rsp_t;

endpackage

FILE: sv/sacc_serial_unit.sv
// Bit-serial add/subtract, shift-add multiply and restoring divide with saturation.
module sacc_serial_unit #(
    parameter int unsigned LIMIT = 999999
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sacc_pkg::req_t  req,
    output sacc_pkg::rsp_t  rsp
);

    localparam logic [2:0] CS_IDLE = 3'd0;
    localparam logic [2:0] CS_ADD  = 3'd1;
    localparam logic [2:0] CS_MUL  = 3'd2;
    localparam logic [2:0] CS_DIV  = 3'd3;
    localparam logic [2:0] CS_FIN  = 3'd4;

    localparam sacc_pkg::sum_t  LIM_SUM  = sacc_pkg::sum_t'(LIMIT);
    localparam sacc_pkg::acc_t  LIM_ACC  = sacc_pkg::acc_t'(LIMIT);
    localparam sacc_pkg::mag_t  LIM_MAG  = sacc_pkg::mag_t'(LIMIT);
    localparam sacc_pkg::prod_t LIM_PROD = sacc_pkg::prod_t'(LIMIT);

    logic [2:0]           state_reg, state_next;
    logic [4:0]           count_reg, count_next;
    sacc_pkg::sum_t       a_reg, a_next;
    sacc_pkg::sum_t       b_reg, b_next;
    logic                 carry_reg, carry_next;
    logic [20:0]          hi_reg, hi_next;
    sacc_pkg::mag_t       lo_reg, lo_next;
    sacc_pkg::mag_t       mcand_reg, mcand_next;
    logic [1:0]           op_reg, op_next;
    logic                 neg_reg, neg_next;
    logic                 done_reg, done_next;
    sacc_pkg::acc_t       res_reg, res_next;

    logic [20:0]          acc_negated;
    sacc_pkg::mag_t       acc_abs;
    logic [9:0]           opd_pos;
    logic [9:0]           opd_tc;
    logic                 is_sub;
    logic                 sum_bit;
    logic                 sum_carry;
    logic [20:0]          mul_sum;
    logic [9:0]           trial;
    logic [10:0]          diff;
    sacc_pkg::prod_t      prod;
    sacc_pkg::mag_t       clamp_mag;
    logic [20:0]          mag_ext;
    sacc_pkg::acc_t       mag_res;
    sacc_pkg::acc_t       add_res;

    assign acc_negated = -req.acc;
    assign acc_abs     = req.acc[20] ? acc_negated[19:0] : req.acc[19:0];
    assign opd_pos     = {1'b0, req.opd_mag};
    assign opd_tc      = req.opd_neg ? -opd_pos : opd_pos;
    assign is_sub      = (req.op == sacc_pkg::OP_SUB);

    assign sum_bit   = a_reg[0] ^ b_reg[0] ^ carry_reg;
    assign sum_carry = (a_reg[0] & b_reg[0]) | (carry_reg & (a_reg[0] ^ b_reg[0]));

    assign mul_sum = hi_reg + {1'b0, (lo_reg[0] ? mcand_reg : '0)};

    assign trial = {hi_reg[8:0], lo_reg[19]};
    assign diff  = {1'b0, trial} - {2'b00, mcand_reg[8:0]};

    assign prod      = (op_reg == sacc_pkg::OP_MUL) ? {hi_reg[19:0], lo_reg[8:0]}
                                                    : {9'd0, lo_reg};
    assign clamp_mag = (prod > LIM_PROD) ? LIM_MAG : prod[19:0];
    assign mag_ext   = {1'b0, clamp_mag};
    assign mag_res   = neg_reg ? -$signed(mag_ext) : $signed(mag_ext);

    always_comb
    begin
        if ($signed(a_reg) > $signed(LIM_SUM))
        begin
            add_res = LIM_ACC;
        end
        else if ($signed(a_reg) < -$signed(LIM_SUM))
        begin
            add_res = -LIM_ACC;
        end
        else
        begin
            add_res = $signed(a_reg[20:0]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        carry_next = carry_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        mcand_next = mcand_reg;
        op_next    = op_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    neg_next = req.acc[20] ^ req.opd_neg;
                    hi_next  = '0;
                    if (req.op == sacc_pkg::OP_ADD || req.op == sacc_pkg::OP_SUB)
                    begin
                        a_next     = {req.acc[20], req.acc};
                        b_next     = {{12{opd_tc[9]}}, opd_tc} ^ {sacc_pkg::SUM_W{is_sub}};
                        carry_next = is_sub;
                        count_next = 5'(sacc_pkg::SUM_W - 1);
                        state_next = CS_ADD;
                    end
                    else if (req.op == sacc_pkg::OP_MUL)
                    begin
                        mcand_next = acc_abs;
                        lo_next    = {11'd0, req.opd_mag};
                        count_next = 5'(sacc_pkg::OPD_W - 1);
                        state_next = CS_MUL;
                    end
                    else
                    begin
                        mcand_next = {11'd0, req.opd_mag};
                        lo_next    = acc_abs;
                        count_next = 5'(sacc_pkg::MAG_W - 1);
                        state_next = CS_DIV;
                    end
                end
            end
            CS_ADD:
            begin
                a_next     = {sum_bit, a_reg[21:1]};
                b_next     = {1'b0, b_reg[21:1]};
                carry_next = sum_carry;
                count_next = count_reg - 5'd1;
                if (count_reg == 5'd0)
                begin
                    state_next = CS_FIN;
                end
            end
            CS_MUL:
            begin
                hi_next    = {1'b0, mul_sum[20:1]};
                lo_next    = {lo_reg[19:9], mul_sum[0], lo_reg[8:1]};
                count_next = count_reg - 5'd1;
                if (count_reg == 5'd0)
                begin
                    state_next = CS_FIN;
                end
            end
            CS_DIV:
            begin
                if (!diff[10])
                begin
                    hi_next = {11'd0, diff[9:0]};
                end
                else
                begin
                    hi_next = {11'd0, trial};
                end
                lo_next    = {lo_reg[18:0], !diff[10]};
                count_next = count_reg - 5'd1;
                if (count_reg == 5'd0)
                begin
                    state_next = CS_FIN;
                end
            end
            CS_FIN:
            begin
                if (op_reg == sacc_pkg::OP_ADD || op_reg == sacc_pkg::OP_SUB)
                begin
                    res_next = add_res;
                end
                else
                begin
                    res_next = mag_res;
                end
                done_next  = 1'b1;
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        carry_reg <= carry_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        mcand_reg <= mcand_next;
        op_reg    <= op_next;
        neg_reg   <= neg_next;
        res_reg   <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

FILE: sv/saturating_accumulator_alu.sv
// Saturating accumulator ALU: command decode, accumulator state and result register.
// Add and subtract run through a 22-bit serial adder, multiply steps through the 9
// multiplier bits and divide forms 20 quotient bits; stop, ignored commands and divide
// by zero bypass the serial unit. A new item is taken in the cycle after the previous
// result is loaded, never while an item is still in progress.
// Reset clears the accumulator and the stop flag and empties the result register.
module saturating_accumulator_alu #(
    parameter int unsigned LIMIT = 999999
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  sacc_pkg::in_t   req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output sacc_pkg::out_t  rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_PEND = 2'd2;

    logic [1:0]        state_reg, state_next;
    sacc_pkg::acc_t    acc_reg, acc_next;
    logic              halt_reg, halt_next;
    logic              out_valid_reg, out_valid_next;
    sacc_pkg::out_t    out_reg, out_next;

    logic              accept;
    logic              need_core;
    sacc_pkg::opd_t    opd_mag;
    sacc_pkg::req_t    core_req;
    sacc_pkg::rsp_t    core_rsp;
    logic [1:0]        op;

    assign opd_mag   = req.switches[8:0];
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        op        = sacc_pkg::OP_ADD;
        need_core = 1'b0;
        if (!halt_reg)
        begin
            if (req.cmd == sacc_pkg::CMD_ADD)
            begin
                op        = sacc_pkg::OP_ADD;
                need_core = 1'b1;
            end
            else if (req.cmd == sacc_pkg::CMD_SUB)
            begin
                op        = sacc_pkg::OP_SUB;
                need_core = 1'b1;
            end
            else if (req.cmd == sacc_pkg::CMD_MUL)
            begin
                op        = sacc_pkg::OP_MUL;
                need_core = 1'b1;
            end
            else if (req.cmd == sacc_pkg::CMD_DIV && opd_mag != '0)
            begin
                op        = sacc_pkg::OP_DIV;
                need_core = 1'b1;
            end
        end
    end

    assign core_req.start   = accept && need_core;
    assign core_req.op      = op;
    assign core_req.acc     = acc_reg;
    assign core_req.opd_mag = opd_mag;
    assign core_req.opd_neg = req.switches[9];

    sacc_serial_unit #(
        .LIMIT (LIMIT)
    ) u_serial (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (core_req),
        .rsp   (core_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        halt_next      = halt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (need_core)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        if (!halt_reg && req.cmd == sacc_pkg::CMD_STOP)
                        begin
                            halt_next = 1'b1;
                        end
                        state_next = ST_PEND;
                    end
                end
            end
            ST_RUN:
            begin
                if (core_rsp.done)
                begin
                    acc_next   = core_rsp.result;
                    state_next = ST_PEND;
                end
            end
            ST_PEND:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next.accumulator = acc_reg;
                    out_next.negative    = acc_reg[20];
                    out_next.stopped     = halt_reg;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

FILE: tb/sv/tb_saturating_accumulator_alu.sv
// Self-checking testbench for the saturating accumulator ALU.
`timescale 1ns / 100ps

module tb_saturating_accumulator_alu;

    localparam longint ACC_LIMIT = 999999;

    typedef struct {
        logic [3:0] cmd;
        logic [9:0] sw;
        bit         typed;
        int         want;
    } plan_row_t;

    plan_row_t plan_rows [23] = '{
        '{4'd0,                10'h000, 1'b1, 0},
        '{sacc_pkg::CMD_ADD,  10'h1FF, 1'b1, 511},
        '{sacc_pkg::CMD_ADD,  10'h200, 1'b0, 0},
        '{sacc_pkg::CMD_SUB,  10'h3FF, 1'b0, 0},
        '{sacc_pkg::CMD_MUL,  10'h1FF, 1'b0, 0},
        '{sacc_pkg::CMD_MUL,  10'h1FF, 1'b1, 999999},
        '{sacc_pkg::CMD_ADD,  10'h001, 1'b1, 999999},
        '{sacc_pkg::CMD_DIV,  10'h000, 1'b1, 999999},
        '{sacc_pkg::CMD_DIV,  10'h200, 1'b1, 999999},
        '{sacc_pkg::CMD_DIV,  10'h3FF, 1'b0, 0},
        '{sacc_pkg::CMD_MUL,  10'h1FF, 1'b0, 0},
        '{sacc_pkg::CMD_SUB,  10'h1FF, 1'b1, -999999},
        '{sacc_pkg::CMD_ADD,  10'h3FF, 1'b1, -999999},
        '{sacc_pkg::CMD_DIV,  10'h002, 1'b0, 0},
        '{sacc_pkg::CMD_DIV,  10'h3FE, 1'b0, 0},
        '{4'd3,                10'h155, 1'b0, 0},
        '{4'd5,                10'h2AA, 1'b0, 0},
        '{4'd15,               10'h3FF, 1'b0, 0},
        '{4'd12,               10'h000, 1'b0, 0},
        '{sacc_pkg::CMD_MUL,  10'h200, 1'b1, 0},
        '{sacc_pkg::CMD_SUB,  10'h3FF, 1'b0, 0},
        '{sacc_pkg::CMD_DIV,  10'h3FF, 1'b0, 0},
        '{sacc_pkg::CMD_DIV,  10'h002, 1'b0, 0}
    };

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_stall;
    sacc_pkg::in_t   req = '0;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;
    sacc_pkg::out_t  rsp;

    longint          acc_now = 0;
    bit              halted = 1'b0;
    sacc_pkg::out_t  expected_q [$];
    int              fault_count = 0;
    int              item_count = 0;
    bit              calm = 1'b0;

    saturating_accumulator_alu #(
        .LIMIT(32'(ACC_LIMIT))
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #2 clk = ~clk;

    function automatic sacc_pkg::out_t apply_command(sacc_pkg::in_t item);
        longint         operand;
        longint         next;
        sacc_pkg::out_t res;
        operand = longint'(item.switches[8:0]);
        if (item.switches[9])
        begin
            operand = -operand;
        end
        next = acc_now;
        if (!halted)
        begin
            if (item.cmd == sacc_pkg::CMD_STOP)
            begin
                halted = 1'b1;
            end
            else
            begin
                case (item.cmd)
                    sacc_pkg::CMD_ADD: next = acc_now + operand;
                    sacc_pkg::CMD_SUB: next = acc_now - operand;
                    sacc_pkg::CMD_MUL: next = acc_now * operand;
                    sacc_pkg::CMD_DIV:
                    begin
                        if (operand != 0)
                        begin
                            next = acc_now / operand;
                        end
                    end
                    default: next = acc_now;
                endcase
                if (next > ACC_LIMIT)
                begin
                    next = ACC_LIMIT;
                end
                else if (next < -ACC_LIMIT)
                begin
                    next = -ACC_LIMIT;
                end
                acc_now = next;
            end
        end
        res.accumulator = sacc_pkg::acc_t'(acc_now);
        res.negative    = (acc_now < 0);
        res.stopped     = halted;
        return res;
    endfunction

    function automatic sacc_pkg::in_t random_item(bit with_stop);
        sacc_pkg::in_t item;
        case ($urandom_range(0, 9))
            0, 1: item.cmd = sacc_pkg::CMD_ADD;
            2, 3: item.cmd = sacc_pkg::CMD_SUB;
            4, 5: item.cmd = sacc_pkg::CMD_MUL;
            6, 7: item.cmd = sacc_pkg::CMD_DIV;
            default:
            begin
                do
                    item.cmd = 4'($urandom_range(0, 15));
                while (!with_stop && item.cmd == sacc_pkg::CMD_STOP);
            end
        endcase
        case ($urandom_range(0, 7))
            0: item.switches = 10'h000;
            1: item.switches = 10'h200;
            2: item.switches = 10'h1FF;
            3: item.switches = 10'h3FF;
            4, 5: item.switches = {1'($urandom_range(0, 1)), 9'($urandom_range(0, 3))};
            default: item.switches = 10'($urandom_range(0, 1023));
        endcase
        return item;
    endfunction

    task automatic offer(sacc_pkg::in_t item, bit typed, int want);
        sacc_pkg::out_t exp_res;
        if (!calm && (item_count % 50) >= 10 && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        exp_res = apply_command(item);
        if (typed)
        begin
            exp_res.accumulator = sacc_pkg::acc_t'(want);
            exp_res.negative    = (want < 0);
            exp_res.stopped     = 1'b0;
        end
        expected_q.push_back(exp_res);
        item_count++;
    endtask

    initial
    begin
        sacc_pkg::in_t item;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_rows[i])
        begin
            item.cmd      = plan_rows[i].cmd;
            item.switches = plan_rows[i].sw;
            offer(item, plan_rows[i].typed, plan_rows[i].want);
        end

        for (int n = 0; n < 600; n++)
        begin
            if (n == 300)
            begin
                req_valid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_q.size() != 0);
            end
            if (n == 540)
            begin
                calm = 1'b1;
            end
            offer(random_item(1'b0), 1'b0, 0);
        end

        item.cmd      = sacc_pkg::CMD_STOP;
        item.switches = 10'($urandom_range(0, 1023));
        offer(item, 1'b0, 0);
        repeat (24) offer(random_item(1'b1), 1'b0, 0);
        req_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fault_count == 0 && expected_q.size() == 0)
        begin
            $display("tb_saturating_accumulator_alu: done, clean");
        end
        else
        begin
            $display("tb_saturating_accumulator_alu: done, errors");
        end
        $finish;
    end

    initial
    begin
        int unsigned cycle_no;
        bit          long_done;
        cycle_no  = 0;
        long_done = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (!long_done && cycle_no >= 3000)
            begin
                long_done = 1'b1;
                rsp_stall <= 1'b1;
                repeat (400) @(posedge clk);
                cycle_no += 400;
                rsp_stall <= 1'b0;
            end
            else if (!calm && (cycle_no % 800) >= 150 && $urandom_range(0, 7) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        sacc_pkg::out_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: accumulator %0d", rsp.accumulator);
                fault_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (rsp.accumulator !== want.accumulator)
                begin
                    $error("accumulator: expected %0d, got %0d",
                           want.accumulator, rsp.accumulator);
                    fault_count++;
                end
                if (rsp.negative !== want.negative)
                begin
                    $error("negative: expected %0b, got %0b", want.negative, rsp.negative);
                    fault_count++;
                end
                if (rsp.stopped !== want.stopped)
                begin
                    $error("stopped: expected %0b, got %0b", want.stopped, rsp.stopped);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("tb_saturating_accumulator_alu: done, errors");
        $finish;
    end

endmodule
